// ===== rtl/eanht_pkg.sv =====
// Package: shared types and constants for the energy-aware next-hop table.
package eanht_pkg;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_NOT_QUAL = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CHOSEN   = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;

  localparam logic [1:0] CFG_LEVEL   = 2'd0;
  localparam logic [1:0] CFG_HWEIGHT = 2'd1;
  localparam logic [1:0] CFG_EWEIGHT = 2'd2;
  localparam logic [1:0] CFG_RWEIGHT = 2'd3;

  localparam logic       MODE_REPORT = 1'b0;
  localparam logic       MODE_SELECT = 1'b1;

  // Score is 1000*wh*hr + 1000*we*er + 65536*wr*rssi; fits in 48 signed bits.
  localparam int SCORE_W = 48;
  // Threshold -10 * 2^32.
  localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = -48'sd42949672960;

  typedef struct packed {
    logic              mode;
    logic [15:0]       neighbour_id;
    logic [7:0]        sender_level;
    logic [16:0]       energy_ratio;
    logic [16:0]       harvest_ratio;
    logic signed [7:0] signal_strength;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_hop;
  } out_word_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DECIDE,
    BK_OUT
  } bk_state_t;

endpackage

// ===== rtl/eanht_front.sv =====
// Front end: a two-deep queue of accepted words.
module eanht_front import eanht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output in_word_t q_data
);

  in_word_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  // Store accepted words in order.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem_r[wp_r] <= in_data;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((in_valid && in_ready) ? 1 : 0)
                     - 2'((q_pop && q_valid) ? 1 : 0);
    end
  end

  property p_no_over;
    @(posedge clk) disable iff (!rst_n) cnt_r == 2'd2 |-> !in_ready;
  endproperty
  a_no_over: assert property (p_no_over) else $error("queue overflow");

  property p_pop_valid;
    @(posedge clk) disable iff (!rst_n) cnt_r == 2'd0 |-> !q_valid;
  endproperty
  a_pop_valid: assert property (p_pop_valid) else $error("empty queue shows valid");

  property p_cnt_range;
    @(posedge clk) disable iff (!rst_n) cnt_r != 2'd3;
  endproperty
  a_cnt_range: assert property (p_cnt_range) else $error("queue count out of range");

endmodule

// ===== rtl/eanht_back.sv =====
// Back end: walks the neighbour table one slot per cycle for reports and selects.
module eanht_back import eanht_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  in_word_t    q_data,
  input  logic [7:0]  own_level,
  input  logic [16:0] h_weight,
  input  logic [16:0] e_weight,
  input  logic [16:0] r_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  // Table: ids, ratios and signals in flops, valid bits cleared at reset.
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [15:0]            id_r  [TABLE_DEPTH];
  logic [16:0]            en_r  [TABLE_DEPTH];
  logic [16:0]            hv_r  [TABLE_DEPTH];
  logic signed [7:0]      sg_r  [TABLE_DEPTH];
  logic [CW-1:0]          count_r;

  bk_state_t st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  // scan results
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic [15:0]   hop_r, hop_nxt;
  logic          any_r, any_nxt;
  out_word_t     res_r, res_nxt;

  // Product stage: three products registered, then summed and compared.
  logic                      p_vld_r;
  logic [IW-1:0]             p_idx_r;
  logic [33:0]               ph_r, pe_r;
  logic signed [25:0]        pr_r;
  logic signed [SCORE_W-1:0] score;

  logic [IW-1:0] ix;
  assign ix = idx_r;

  always_ff @(posedge clk) begin
    ph_r    <= h_weight * hv_r[ix];
    pe_r    <= e_weight * en_r[ix];
    pr_r    <= $signed({1'b0, r_weight}) * sg_r[ix];
    p_idx_r <= ix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else        p_vld_r <= (st_r == BK_SCAN) && q_data.mode == MODE_SELECT
                           && vld_r[ix];
  end

  assign score = SCORE_W'(({14'd0, ph_r} + {14'd0, pe_r}) * 48'd1000)
               + ({{(SCORE_W-42){pr_r[25]}}, pr_r, 16'd0});

  // Next state and per-cycle updates.
  always_comb begin
    st_nxt       = st_r;
    idx_nxt      = idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    best_nxt     = best_r;
    hop_nxt      = hop_r;
    any_nxt      = any_r;
    res_nxt      = res_r;
    q_pop        = 1'b0;
    // fold in a score from the product stage
    if (p_vld_r && score > best_r) begin
      best_nxt = score;
      hop_nxt  = id_r[p_idx_r];
      any_nxt  = 1'b1;
    end
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          st_nxt   = BK_SCAN;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          best_nxt = SCORE_FLOOR;
          any_nxt  = 1'b0;
          hop_nxt  = '0;
        end
      end
      BK_SCAN: begin
        if (vld_r[ix] && id_r[ix] == q_data.neighbour_id && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = ix;
        end
        if (!vld_r[ix] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = ix;
        end
        if (ix == LAST) st_nxt = BK_DRAIN;
        else            idx_nxt = ix + 1'b1;
      end
      BK_DRAIN: st_nxt = BK_DECIDE;
      BK_DECIDE: begin
        if (q_data.mode == MODE_SELECT) begin
          res_nxt.status   = any_r ? ST_CHOSEN : ST_NONE;
          res_nxt.next_hop = any_r ? hop_r : 16'd0;
        end else begin
          res_nxt.next_hop = 16'd0;
          if (hit_r) res_nxt.status = ST_UPDATED;
          else if (own_level == 8'hFF || {1'b0, own_level} != {1'b0, q_data.sender_level} + 9'd1)
            res_nxt.status = ST_NOT_QUAL;
          else if (count_r >= FULL || !free_r) res_nxt.status = ST_FULL;
          else res_nxt.status = ST_INSERTED;
        end
        q_pop  = 1'b1;
        st_nxt = BK_OUT;
      end
      BK_OUT: if (out_ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_IDLE;
      vld_r <= '0;
      count_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_DECIDE && q_data.mode == MODE_REPORT
          && res_nxt.status == ST_INSERTED) begin
        vld_r[free_idx_r] <= 1'b1;
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Write table entries on update or insert.
  always_ff @(posedge clk) begin
    if (st_r == BK_DECIDE && q_data.mode == MODE_REPORT) begin
      if (res_nxt.status == ST_UPDATED) begin
        en_r[hit_idx_r] <= q_data.energy_ratio;
        hv_r[hit_idx_r] <= q_data.harvest_ratio;
        sg_r[hit_idx_r] <= q_data.signal_strength;
      end else if (res_nxt.status == ST_INSERTED) begin
        id_r[free_idx_r] <= q_data.neighbour_id;
        en_r[free_idx_r] <= q_data.energy_ratio;
        hv_r[free_idx_r] <= q_data.harvest_ratio;
        sg_r[free_idx_r] <= q_data.signal_strength;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    best_r     <= best_nxt;
    hop_r      <= hop_nxt;
    any_r      <= any_nxt;
    res_r      <= res_nxt;
  end

  assign out_valid = (st_r == BK_OUT);
  assign out_data  = res_r;

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= FULL;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count beyond depth");

  property p_count_match;
    @(posedge clk) disable iff (!rst_n) CW'($countones(vld_r)) == count_r;
  endproperty
  a_count_match: assert property (p_count_match) else $error("count mismatch");

  property p_pop_once;
    @(posedge clk) disable iff (!rst_n) q_pop |-> q_valid && st_r == BK_DECIDE;
  endproperty
  a_pop_once: assert property (p_pop_once) else $error("pop without word");

endmodule

// ===== rtl/energy_aware_next_hop_table_core.sv =====
// Top level: energy-aware neighbour table with next-hop choice.
//  channel | ports                         | direction
//  input   | in_valid in_ready in_data     | in
//  result  | out_valid out_ready out_data  | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in
// In the back end each word passes a dispatch, a walk of the table one slot
// per cycle, a drain of the product register, a decide and an output.
// A two-word queue lets new words be accepted while a result waits.
// Reset (synchronous) clears valid bits, count, state and queue; config gets defaults.
// A stalled output holds the back end; the queue then fills and drops in_ready.
module energy_aware_next_hop_table_core import eanht_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic [7:0]  level_r;
  logic [16:0] hw_r, ew_r, rw_r;
  logic        q_valid, q_pop;
  in_word_t    q_data;

  assign cfg_ready = 1'b1;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 8'hFF;
      hw_r    <= '0;
      ew_r    <= '0;
      rw_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEVEL:   level_r <= cfg_data[7:0];
        CFG_HWEIGHT: hw_r    <= cfg_data;
        CFG_EWEIGHT: ew_r    <= cfg_data;
        CFG_RWEIGHT: rw_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  eanht_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  eanht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .own_level(level_r), .h_weight(hw_r), .e_weight(ew_r), .r_weight(rw_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// ===== sim/tb_energy_aware_next_hop_table_core.sv =====
// Testbench for the energy-aware next-hop table: directed and random words checked live.
`timescale 1ns / 100ps

module tb_energy_aware_next_hop_table_core;
  import eanht_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  energy_aware_next_hop_table_core #(.TABLE_DEPTH(DEPTH)) dut (.*);

  // Predictor copy of the table and registers
  logic [7:0]        own_level;
  logic [16:0]       w_harvest, w_energy, w_rssi;
  logic              tbl_valid [DEPTH];
  logic [15:0]       tbl_id [DEPTH];
  logic [16:0]       tbl_energy [DEPTH];
  logic [16:0]       tbl_harvest [DEPTH];
  logic signed [7:0] tbl_signal [DEPTH];
  int                tbl_count;

  out_word_t pending_results [$];
  int        mismatches;
  bit        failed;
  bit        rx_idle_en;
  bit        tx_idle_en;
  bit        hold_rx;
  int        quiet_cycles;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Update the table model and return the expected result word
  function automatic out_word_t predict_route(in_word_t w);
    out_word_t r;
    longint best, sc;
    int found;
    found = -1;
    r.status = ST_NONE;
    r.next_hop = 16'd0;
    if (w.mode == MODE_REPORT) begin
      for (int s = 0; s < DEPTH; s++)
        if (found < 0 && tbl_valid[s] && tbl_id[s] == w.neighbour_id) found = s;
      if (found >= 0) begin
        tbl_energy[found] = w.energy_ratio;
        tbl_harvest[found] = w.harvest_ratio;
        tbl_signal[found] = w.signal_strength;
        r.status = ST_UPDATED;
      end else if (own_level == 8'd255 || {1'b0, own_level} != {1'b0, w.sender_level} + 9'd1) begin
        r.status = ST_NOT_QUAL;
      end else begin
        r.status = ST_FULL;
        for (int s = 0; s < DEPTH; s++)
          if (r.status == ST_FULL && !tbl_valid[s]) begin
            tbl_valid[s] = 1'b1;
            tbl_id[s] = w.neighbour_id;
            tbl_energy[s] = w.energy_ratio;
            tbl_harvest[s] = w.harvest_ratio;
            tbl_signal[s] = w.signal_strength;
            tbl_count++;
            r.status = ST_INSERTED;
          end
      end
    end else begin
      best = -64'sd42949672960;
      for (int s = 0; s < DEPTH; s++)
        if (tbl_valid[s]) begin
          sc = 64'sd1000 * longint'(w_harvest) * longint'(tbl_harvest[s])
             + 64'sd1000 * longint'(w_energy) * longint'(tbl_energy[s])
             + longint'(w_rssi) * longint'(tbl_signal[s]) * 64'sd65536;
          if (sc > best) begin
            best = sc;
            r.next_hop = tbl_id[s];
            r.status = ST_CHOSEN;
          end
        end
    end
    return r;
  endfunction

  // Send one word, predicting its result at acceptance; valid stays up for the next word
  task automatic send_word(in_word_t w);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_route(w));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEVEL:   own_level = val[7:0];
      CFG_HWEIGHT: w_harvest = val;
      CFG_EWEIGHT: w_energy = val;
      default:     w_rssi = val;
    endcase
    @(posedge clk);
  endtask

  // Drop valid, wait for all results, then let the back end settle
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  function automatic in_word_t report_word(logic [15:0] id, logic [7:0] lvl);
    in_word_t w;
    w.mode = MODE_REPORT;
    w.neighbour_id = id;
    w.sender_level = lvl;
    w.energy_ratio = 17'($urandom);
    w.harvest_ratio = 17'($urandom);
    w.signal_strength = 8'($urandom);
    if ($urandom_range(0, 1)) begin
      w.energy_ratio = 17'($urandom_range(0, 65536));
      w.harvest_ratio = 17'($urandom_range(0, 65536));
    end
    return w;
  endfunction

  function automatic in_word_t select_word();
    in_word_t w;
    w = in_word_t'({$urandom, $urandom});
    w.mode = MODE_SELECT;
    return w;
  endfunction

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        if (mismatches++ < 10) $display("unexpected result %p", out_data);
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data.status !== exp_w.status || out_data.next_hop !== exp_w.next_hop) begin
          failed = 1'b1;
          if (mismatches++ < 10)
            $display("mismatch: expected status %0d hop %0h, got status %0d hop %0h",
                     exp_w.status, exp_w.next_hop, out_data.status, out_data.next_hop);
        end
      end
    end
  end

  // Receiver stalls in random bursts, or holds off entirely on request
  always @(posedge clk) begin
    if (!rst_n || hold_rx) begin
      out_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(posedge clk);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || hold_rx)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("tb_energy_aware_next_hop_table_core NOT OK");
      $finish;
    end
  end

  task automatic test_edges;
    in_word_t w;
    // Not joined: nothing qualifies, select finds none
    send_word(report_word(16'h1234, 8'd254));
    send_word(select_word());
    drain();
    write_reg(CFG_LEVEL, 17'd255);
    send_word(report_word(16'h0001, 8'd254));
    drain();
    write_reg(CFG_LEVEL, 17'd0);
    send_word(report_word(16'h0002, 8'd255));
    drain();
    write_reg(CFG_LEVEL, 17'd5);
    write_reg(CFG_HWEIGHT, 17'd65536);
    write_reg(CFG_EWEIGHT, 17'd0);
    write_reg(CFG_RWEIGHT, 17'h1FFFF);
    // Id zero, extremes, update, ties
    w = report_word(16'h0000, 8'd4);
    w.energy_ratio = 17'h1FFFF; w.harvest_ratio = 17'h1FFFF; w.signal_strength = 8'sd127;
    send_word(w);
    send_word(select_word());
    w.neighbour_id = 16'hFFFF; w.signal_strength = -8'sd128;
    w.energy_ratio = 17'd0; w.harvest_ratio = 17'd0;
    send_word(w);
    send_word(w);
    send_word(select_word());
    w.neighbour_id = 16'h0000; w.harvest_ratio = 17'd0; w.signal_strength = -8'sd128;
    send_word(w);
    send_word(select_word());
    w.sender_level = 8'd9;
    w.neighbour_id = 16'h5555;
    send_word(w);
    // Fill the table then overflow
    for (int i = 0; i < DEPTH; i++) send_word(report_word(16'h0100 + 16'(i), 8'd4));
    send_word(select_word());
    drain();
  endtask

  task automatic test_random_phase(int items, bit idle);
    in_word_t w;
    tx_idle_en = idle;
    rx_idle_en = idle;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_word(select_word());
      end else begin
        w = report_word(16'($urandom_range(0, 40)), own_level - 8'd1);
        if ($urandom_range(0, 9) == 0) w.sender_level = 8'($urandom);
        if ($urandom_range(0, 9) == 0) w.neighbour_id = 16'($urandom);
        send_word(w);
      end
    end
    drain();
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_word(select_word());
    join
    drain();
  endtask

  task automatic reset_table;
    own_level = 8'd255;
    w_harvest = '0; w_energy = '0; w_rssi = '0;
    tbl_count = 0;
    for (int s = 0; s < DEPTH; s++) begin
      tbl_valid[s] = 1'b0; tbl_id[s] = '0; tbl_energy[s] = '0;
      tbl_harvest[s] = '0; tbl_signal[s] = '0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    out_ready = 1'b0;
    hold_rx = 1'b0; rx_idle_en = 1'b0; tx_idle_en = 1'b0;
    mismatches = 0; failed = 1'b0; quiet_cycles = 0;
    reset_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges();
    test_backpressure();
    // Several weight settings, extremes among them
    write_reg(CFG_LEVEL, 17'd3);
    write_reg(CFG_HWEIGHT, 17'd0);
    write_reg(CFG_EWEIGHT, 17'd65536);
    write_reg(CFG_RWEIGHT, 17'd0);
    test_random_phase(500, 1'b1);
    write_reg(CFG_LEVEL, 17'd200);
    write_reg(CFG_HWEIGHT, 17'($urandom_range(0, 65536)));
    write_reg(CFG_EWEIGHT, 17'($urandom_range(0, 65536)));
    write_reg(CFG_RWEIGHT, 17'($urandom_range(0, 65536)));
    test_random_phase(500, 1'b1);
    write_reg(CFG_LEVEL, 17'd1);
    write_reg(CFG_HWEIGHT, 17'h1FFFF);
    write_reg(CFG_EWEIGHT, 17'h1FFFF);
    write_reg(CFG_RWEIGHT, 17'd65536);
    test_random_phase(500, 1'b1);
    write_reg(CFG_RWEIGHT, 17'($urandom));
    test_random_phase(400, 1'b0);

    if (!failed && pending_results.size() == 0)
      $display("tb_energy_aware_next_hop_table_core OK");
    else
      $display("tb_energy_aware_next_hop_table_core NOT OK");
    $finish;
  end

endmodule
